// ----- sv/dmic_pkg.sv -----
package dmic_pkg;

    // Cache geometry. Both counts must be powers of two.
    localparam int LINES          = 128;
    localparam int WORDS_PER_LINE = 16;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 32;
    localparam int BYTE_W = 2;
    localparam int WSEL_W = $clog2(WORDS_PER_LINE);
    localparam int IDX_W  = $clog2(LINES);
    localparam int TAG_W  = ADDR_W - BYTE_W - WSEL_W - IDX_W;
    localparam int WORDS  = LINES * WORDS_PER_LINE;

    // Stream payload widths.
    localparam int IN_TDATA_W   = ADDR_W + DATA_W;
    localparam int OUT_FIELDS_W = 1 + DATA_W + 2 + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes carried on the slave tuser bit.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_REFILL = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_BYPASS = 2'd2
    } t_action;

endpackage

// ----- sv/dmic_ram.sv -----
module dmic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port; the read register holds whenever the port is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/direct_mapped_icache_second_chance.sv -----
// Direct-mapped instruction cache with second-chance replacement.
// The slave stream carries one request per transfer: tuser selects a lookup of
// a fetch address or the write of one refill word, and tdata holds the byte
// address and the refill word. The master stream returns exactly one result
// per request: the hit flag, the cached word (zero unless hit), the miss
// action (allocate or bypass) and the running count of lookup hits.
// A request taken at a clock edge reads the tag and word memories at that
// edge, is resolved in the resolve stage and is registered into the output
// register, which drives the master side. Throughput is one request per
// cycle while the receiver does not stall; the single port of each memory
// is used once per request, to read for a lookup or to write for a refill.
// At reset the valid and second-chance bits and the hit counter clear in the
// same cycle, so there is no clearing pass; tag and word storage stay unset
// and are only used once a refill has made their line valid.
// When the receiver stalls, the result waits in the output register, one
// more request can be taken into the resolve stage, and then tready drops
// until the waiting result is transferred.
module direct_mapped_icache_second_chance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] address, [63:32] fill_word
    input  logic [dmic_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] operation
    input  logic                             i_s_tuser,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] hit, [32:1] read_word, [34:33] miss_action, [66:35] hit_count,
    // upper bits zero
    output logic [dmic_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int ADDR_W = dmic_pkg::ADDR_W;
    localparam int BYTE_W = dmic_pkg::BYTE_W;
    localparam int WSEL_W = dmic_pkg::WSEL_W;
    localparam int IDX_W  = dmic_pkg::IDX_W;
    localparam int TAG_W  = dmic_pkg::TAG_W;
    localparam int DATA_W = dmic_pkg::DATA_W;
    localparam int CNT_W  = dmic_pkg::CNT_W;
    localparam int LINES  = dmic_pkg::LINES;
    localparam int PAD_W  = dmic_pkg::OUT_TDATA_W - dmic_pkg::OUT_FIELDS_W;

    // Request fields, split straight from the slave side.
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_fill;
    logic [WSEL_W-1:0] in_wsel;
    logic [IDX_W-1:0]  in_idx;
    logic [TAG_W-1:0]  in_tag;
    logic              in_refill;
    logic              accept;

    assign in_addr   = i_s_tdata[ADDR_W-1:0];
    assign in_fill   = i_s_tdata[ADDR_W +: DATA_W];
    assign in_wsel   = in_addr[BYTE_W +: WSEL_W];
    assign in_idx    = in_addr[BYTE_W + WSEL_W +: IDX_W];
    assign in_tag    = in_addr[ADDR_W-1 -: TAG_W];
    assign in_refill = (i_s_tuser == dmic_pkg::OP_REFILL);
    assign accept    = i_s_tvalid && o_s_tready;

    // Tag and word memories. A refill writes both at the edge it is taken,
    // and a lookup reads both at that edge. Since requests reach the memories
    // in order, a lookup always sees every earlier refill. An allocation need
    // not write the tag, as the line then stays invalid until a refill writes
    // the tag again, so only refills write it.
    logic [TAG_W-1:0]  tag_q;
    logic [DATA_W-1:0] word_q;

    dmic_ram #(
        .WIDTH (TAG_W),
        .DEPTH (LINES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (in_refill),
        .i_addr  (in_idx),
        .i_wdata (in_tag),
        .o_rdata (tag_q)
    );

    dmic_ram #(
        .WIDTH (DATA_W),
        .DEPTH (dmic_pkg::WORDS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (in_refill),
        .i_addr  ({in_idx, in_wsel}),
        .i_wdata (in_fill),
        .o_rdata (word_q)
    );

    // Resolve stage: the request alongside the registered memory data.
    logic              r_s1_valid;
    logic              r_s1_refill;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [TAG_W-1:0]  r_s1_tag;

    // Line state, cleared at reset.
    logic [LINES-1:0]  r_valid;
    logic [LINES-1:0]  r_chance;
    logic [LINES-1:0]  n_valid;
    logic [LINES-1:0]  n_chance;

    // Output register.
    logic              r_out_valid;
    logic              r_hit;
    logic [DATA_W-1:0] r_rd;
    dmic_pkg::t_action r_act;
    logic [CNT_W-1:0]  r_hits;

    logic              n_hit;
    logic [DATA_W-1:0] n_rd;
    dmic_pkg::t_action n_act;
    logic [CNT_W-1:0]  n_hits;
    logic              s1_move;
    logic              line_valid;
    logic              line_chance;

    assign s1_move     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_s1_valid || s1_move;
    assign line_valid  = r_valid[r_s1_idx];
    assign line_chance = r_chance[r_s1_idx];

    always_comb begin
        n_hit    = 1'b0;
        n_rd     = '0;
        n_act    = dmic_pkg::ACT_NONE;
        n_hits   = r_hits;
        n_valid  = r_valid;
        n_chance = r_chance;
        if (r_s1_refill) begin
            // Refill: the line becomes valid, its chance bit is left alone.
            n_valid[r_s1_idx] = 1'b1;
        end else if (line_valid && (tag_q == r_s1_tag)) begin
            n_hit              = 1'b1;
            n_rd               = word_q;
            n_hits             = r_hits + CNT_W'(1);
            n_chance[r_s1_idx] = 1'b1;
        end else if (line_valid && line_chance) begin
            // The line earns a second chance: keep it, clear the bit.
            n_act              = dmic_pkg::ACT_BYPASS;
            n_chance[r_s1_idx] = 1'b0;
        end else begin
            n_act              = dmic_pkg::ACT_ALLOC;
            n_valid[r_s1_idx]  = 1'b0;
            n_chance[r_s1_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_chance    <= '0;
            r_hits      <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_valid     <= n_valid;
                r_chance    <= n_chance;
                r_hits      <= n_hits;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_refill <= in_refill;
            r_s1_idx    <= in_idx;
            r_s1_tag    <= in_tag;
        end
        if (s1_move) begin
            r_hit <= n_hit;
            r_rd  <= n_rd;
            r_act <= n_act;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_hits, r_act, r_rd, r_hit};

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_out_valid && !i_m_tready))
        else $error("request side stalled without a full pipeline");

    a_hit_has_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_hit) |-> (r_act == dmic_pkg::ACT_NONE))
        else $error("hit reported together with a miss action");

    a_miss_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hit) |-> (r_rd == '0))
        else $error("non-zero word returned without a hit");

    a_refill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_refill) |=> r_valid[$past(r_s1_idx)])
        else $error("refilled line not marked valid");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W         = dmic_pkg::ADDR_W;
    localparam int DATA_W         = dmic_pkg::DATA_W;
    localparam int CNT_W          = dmic_pkg::CNT_W;
    localparam int BYTE_W         = dmic_pkg::BYTE_W;
    localparam int WSEL_W         = dmic_pkg::WSEL_W;
    localparam int IDX_W          = dmic_pkg::IDX_W;
    localparam int TAG_W          = dmic_pkg::TAG_W;
    localparam int LINES          = dmic_pkg::LINES;
    localparam int WORDS_PER_LINE = dmic_pkg::WORDS_PER_LINE;
    localparam int WORDS          = dmic_pkg::WORDS;
    localparam int IN_TDATA_W     = dmic_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W    = dmic_pkg::OUT_TDATA_W;

    localparam logic OP_LOOKUP = dmic_pkg::OP_LOOKUP;
    localparam logic OP_REFILL = dmic_pkg::OP_REFILL;

    localparam dmic_pkg::t_action ACT_NONE   = dmic_pkg::ACT_NONE;
    localparam dmic_pkg::t_action ACT_ALLOC  = dmic_pkg::ACT_ALLOC;
    localparam dmic_pkg::t_action ACT_BYPASS = dmic_pkg::ACT_BYPASS;

    // Number of requests to issue in total, directed rows included.
    localparam int ITEMS = 550;
    // Cycles without a transfer on either stream before the run is abandoned.
    // Quiet stretches in a correct run come from sender gaps, receiver stalls
    // and the pipeline, so this limit is generous.
    localparam int QUIET_LIMIT = 1000;
    // Requests between the pauses in which the sender waits for every result.
    localparam int DRAIN_EVERY = 180;

    // One expected result. Field order here is for readability only; the
    // packing on the master tdata is unpicked explicitly in the checker.
    typedef struct packed {
        logic              hit;
        logic [31:0]       word;
        dmic_pkg::t_action action;
        logic [31:0]       count;
    } t_cache_result;

    // One row of the directed table. When typed is set the row carries its
    // own expected result; otherwise the predictor supplies it.
    typedef struct packed {
        logic          op;
        logic [31:0]   addr;
        logic [31:0]   fill;
        logic          typed;
        t_cache_result want;
    } t_stim_row;

    localparam t_cache_result BY_PREDICTOR = '0;
    localparam int N_DIRECTED = 22;

    // The directed part walks the corner cases in order: allocation after
    // reset at both ends of the address space, refills of the extreme data
    // values, hits with the ignored low address bits set, a bypass on a line
    // whose chance bit is set, the allocation that follows once it is clear,
    // a partly refilled line that still returns its older words, a refill
    // that re-tags a valid line without a lookup first, and a lookup into
    // the top line with the other tag.
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        {OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, ACT_ALLOC, 32'd0},
        {OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, ACT_ALLOC, 32'd0},
        {OP_REFILL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, ACT_NONE,  32'd0},
        {OP_REFILL, 32'h0000_0004, 32'h0000_0000, 1'b1, 1'b0, 32'h0, ACT_NONE,  32'd0},
        {OP_LOOKUP, 32'h0000_0003, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_0004, 32'hFFFF_FFFF, 1'b0, BY_PREDICTOR},
        {OP_REFILL, 32'hFFFF_FFFC, 32'hA5A5_5A5A, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_2000, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_2004, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_REFILL, 32'h0000_0008, 32'h1234_5678, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_0008, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_REFILL, 32'h0000_2004, 32'h0F0F_0F0F, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_2000, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_2004, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h7FFF_E03C, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_1FC0, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'h0000_1FC0, 32'h0000_0000, 1'b0, BY_PREDICTOR},
        {OP_LOOKUP, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, BY_PREDICTOR}
    };

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = OP_LOOKUP;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    direct_mapped_icache_second_chance u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [31:0] address, [63:32] fill_word
        .i_s_tuser  (s_tuser),   // [0] operation
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)    // [0] hit, [32:1] read_word, [34:33] miss_action,
                                 // [66:35] hit_count
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the cache. The per-word written flags never clear, so
    // that the stimulus can steer away from a hit on a word that has never
    // been filled, which the block is not required to answer sensibly.
    bit [TAG_W-1:0]  shadow_tag   [LINES];
    bit              shadow_valid [LINES];
    bit              shadow_chance[LINES];
    bit [DATA_W-1:0] shadow_words [WORDS];
    bit              word_filled  [WORDS];
    bit [CNT_W-1:0]  hits_so_far;

    t_cache_result results_due[$];
    int            requests_issued;
    int            fail_count;
    int            burst_left;

    // Applies one request to the shadow cache and returns the result the
    // block should give for it.
    function automatic t_cache_result cache_access(logic op, logic [31:0] addr,
                                                   logic [31:0] fill);
        t_cache_result     res;
        logic [TAG_W-1:0]  tg;
        logic [IDX_W-1:0]  ix;
        logic [WSEL_W-1:0] wd;
        int                slot;
        tg   = addr[ADDR_W-1 -: TAG_W];
        ix   = addr[BYTE_W+WSEL_W +: IDX_W];
        wd   = addr[BYTE_W +: WSEL_W];
        slot = int'(ix) * WORDS_PER_LINE + int'(wd);
        res  = '0;
        if (op == OP_REFILL) begin
            // A refill retags the line and makes it valid; the chance bit
            // is left as it was.
            shadow_words[slot] = fill;
            word_filled[slot]  = 1'b1;
            shadow_tag[ix]     = tg;
            shadow_valid[ix]   = 1'b1;
        end else if (shadow_valid[ix] && shadow_tag[ix] == tg) begin
            res.hit           = 1'b1;
            res.word          = shadow_words[slot];
            shadow_chance[ix] = 1'b1;
            hits_so_far       = hits_so_far + 1'b1;
        end else if (shadow_valid[ix] && shadow_chance[ix]) begin
            // Second chance: the resident line survives this miss once.
            shadow_chance[ix] = 1'b0;
            res.action        = ACT_BYPASS;
        end else begin
            shadow_tag[ix]    = tg;
            shadow_valid[ix]  = 1'b0;
            shadow_chance[ix] = 1'b0;
            res.action        = ACT_ALLOC;
        end
        res.count = hits_so_far;
        return res;
    endfunction

    // A lookup that would hit a never-filled word is moved to a filled word
    // of the same line. A valid line always has at least one, as it became
    // valid through a refill and the written flags are never cleared.
    function automatic logic [31:0] avoid_blank_word(logic [31:0] addr);
        logic [IDX_W-1:0] ix;
        logic [31:0]      moved;
        int               base;
        int               picks[$];
        ix    = addr[BYTE_W+WSEL_W +: IDX_W];
        base  = int'(ix) * WORDS_PER_LINE;
        moved = addr;
        if (shadow_valid[ix] && shadow_tag[ix] == addr[ADDR_W-1 -: TAG_W]
                && !word_filled[base + int'(addr[BYTE_W +: WSEL_W])]) begin
            for (int k = 0; k < WORDS_PER_LINE; k++) begin
                if (word_filled[base + k]) begin
                    picks.push_back(k);
                end
            end
            moved[BYTE_W +: WSEL_W] = WSEL_W'(picks[$urandom_range(picks.size() - 1, 0)]);
        end
        return moved;
    endfunction

    function automatic logic [31:0] make_addr(logic [TAG_W-1:0] tg, logic [IDX_W-1:0] ix,
                                              logic [WSEL_W-1:0] wd);
        return {tg, ix, wd, BYTE_W'($urandom_range(3, 0))};
    endfunction

    // Offers one request on the slave stream and holds it until the transfer
    // completes. The sender works in bursts: when a burst is used up, valid
    // may drop for a short random gap and a new burst length is drawn, now and
    // then a long one so that there are stretches with no gaps at all.
    task automatic issue_request(input logic op, input logic [31:0] addr,
                                 input logic [31:0] fill, input logic typed,
                                 input t_cache_result typed_want,
                                 output t_cache_result predicted);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 30)
                                                     : $urandom_range(12, 1);
            gap = $urandom_range(6, 0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {fill, addr};
        do @(posedge clk); while (!s_tready);
        predicted = cache_access(op, addr, fill);
        results_due.push_back(typed ? typed_want : predicted);
        requests_issued++;
    endtask

    task automatic lookup(input logic [31:0] addr, output t_cache_result res);
        issue_request(OP_LOOKUP, avoid_blank_word(addr), 32'($urandom), 1'b0,
                      BY_PREDICTOR, res);
    endtask

    task automatic refill(input logic [31:0] addr, output t_cache_result res);
        issue_request(OP_REFILL, addr, 32'($urandom), 1'b0, BY_PREDICTOR, res);
    endtask

    // Holds the sender back until every outstanding result has been
    // transferred. At least one edge passes, so valid is never lowered and
    // raised again within one time step.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_due.size() != 0);
        burst_left = 0;
    endtask

    // The receiver runs its own pattern, cycling through always ready, mostly
    // ready, a periodic stall and a coin toss.
    logic [8:0] rx_cycle = '0;

    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[8:7])
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(3, 0) != 0);
            end
            2'd2: begin
                m_tready <= (rx_cycle[3:0] < 4'd5);
            end
            default: begin
                m_tready <= ($urandom_range(1, 0) == 1);
            end
        endcase
    end

    // Result checker: every transfer on the master side is matched against
    // the oldest expectation, field by field.
    t_cache_result   want;
    logic            got_hit;
    logic [31:0]     got_word;
    logic [1:0]      got_action;
    logic [31:0]     got_count;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_hit    = m_tdata[0];
            got_word   = m_tdata[DATA_W:1];
            got_action = m_tdata[DATA_W+2:DATA_W+1];
            got_count  = m_tdata[DATA_W+2+CNT_W:DATA_W+3];
            if (results_due.size() == 0) begin
                $error("result transfer with nothing outstanding: hit %0d word %h",
                       got_hit, got_word);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (got_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got_hit);
                    fail_count++;
                end
                if (got_word !== want.word) begin
                    $error("read_word: expected %h, got %h", want.word, got_word);
                    fail_count++;
                end
                if (got_action !== want.action) begin
                    $error("miss_action: expected %0d, got %0d", want.action, got_action);
                    fail_count++;
                end
                if (got_count !== want.count) begin
                    $error("hit_count: expected %0d, got %0d", want.count, got_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither stream moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** direct_mapped_icache_second_chance: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_cache_result     res;
        logic [TAG_W-1:0]  pool_tag[4];
        logic [IDX_W-1:0]  pool_idx[8];
        logic [TAG_W-1:0]  tg;
        logic [IDX_W-1:0]  ix;
        int                kind;
        int                n_fill;
        int                first_word;
        int                n_read;
        int                next_drain;

        burst_left      = 0;
        requests_issued = 0;
        fail_count      = 0;
        hits_so_far     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            issue_request(DIRECTED[r].op, DIRECTED[r].addr, DIRECTED[r].fill,
                          DIRECTED[r].typed, DIRECTED[r].want, res);
        end
        drain_results();

        // A small pool of tags and line indexes keeps conflicts frequent, so
        // that lines are allocated, refilled, hit, bypassed and evicted over
        // and over. The pool always holds the first and the last line.
        foreach (pool_tag[t]) begin
            pool_tag[t] = TAG_W'($urandom);
        end
        foreach (pool_idx[i]) begin
            pool_idx[i] = IDX_W'($urandom);
        end
        pool_idx[0] = '0;
        pool_idx[1] = '1;

        next_drain = requests_issued + DRAIN_EVERY;
        while (requests_issued < ITEMS) begin
            kind = $urandom_range(9, 0);
            tg   = pool_tag[$urandom_range(3, 0)];
            ix   = pool_idx[$urandom_range(7, 0)];
            if (kind < 5) begin
                // The usual miss handling: a fetch misses, the line is filled
                // starting from the missed word (now and then only in part),
                // and the fetch stream then reads around in the line.
                first_word = $urandom_range(WORDS_PER_LINE - 1, 0);
                lookup(make_addr(tg, ix, WSEL_W'(first_word)), res);
                if (res.action == ACT_ALLOC) begin
                    n_fill = ($urandom_range(3, 0) == 0) ? $urandom_range(WORDS_PER_LINE - 1, 1)
                                                         : WORDS_PER_LINE;
                    for (int k = 0; k < n_fill; k++) begin
                        refill(make_addr(tg, ix, WSEL_W'((first_word + k) % WORDS_PER_LINE)),
                               res);
                    end
                end
                n_read = $urandom_range(6, 1);
                for (int k = 0; k < n_read; k++) begin
                    lookup(make_addr(tg, ix, WSEL_W'($urandom)), res);
                end
            end else if (kind < 8) begin
                // Scattered fetches across the pool.
                lookup(make_addr(tg, ix, WSEL_W'($urandom)), res);
            end else if (kind == 8) begin
                // A stray refill word with no miss before it.
                refill(make_addr(tg, ix, WSEL_W'($urandom)), res);
            end else if ($urandom_range(1, 0) == 0) begin
                // Noise anywhere in the address space.
                lookup(32'($urandom), res);
            end else begin
                refill(32'($urandom), res);
            end
            if (requests_issued >= next_drain) begin
                drain_results();
                next_drain = requests_issued + DRAIN_EVERY;
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("** direct_mapped_icache_second_chance: PASSED **");
        end else begin
            $display("** direct_mapped_icache_second_chance: FAILED **");
        end
        $finish;
    end

endmodule
